@@ sv/mefs_pkg.sv @@
// shared types and constants for the momentum exchange force sum unit
package mefs_pkg;

    localparam int FIELD_W     = 24;
    localparam int CFG_W       = 11;
    localparam int SCALE_W     = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int SUM_W       = 48;
    localparam int CONTRIB_W   = 36;
    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 200;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_COEF_SCALE  = 2'd2
    } cfg_reg_t;

    // doubled net contribution of one settled cell
    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic signed [CONTRIB_W-1:0] dx2;
        logic signed [CONTRIB_W-1:0] dy2;
    } settle_req_t;

    // frame totals handed to the coefficient unit
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] drag;
        logic signed [SUM_W-1:0] lift;
        logic                    clip;
    } frame_sum_t;

endpackage

@@ sv/mefs_core.sv @@
// raster sequencer, line buffers, 3x3 solid window and per-cell contribution
module mefs_core
    import mefs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int DIST_BITS  = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   restart,
    input  logic [CFG_W-1:0]       grid_width,
    input  logic [CFG_W-1:0]       grid_height,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_solid,
    input  logic [8*FIELD_W-1:0]   in_dist,
    input  logic                   coef_busy,
    output settle_req_t            req
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT + 2);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int DW   = DIST_BITS;
    localparam int DV_W = 8 * DW;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;

    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;

    logic in_frame;
    logic drain_row;
    logic flush_row;
    logic flush_ok;
    logic step_go;
    logic last_col;

    logic [DV_W-1:0] dist_now;

    logic            p1_valid_reg;
    logic            p1_last_reg;
    logic [XW-1:0]   p1_x_reg;
    logic            p1_x0_reg;
    logic            p1_ge1_reg;
    logic            p1_ge2_reg;
    logic            p1_solid_reg;
    logic [DV_W-1:0] p1_dist_reg;

    logic [1:0]      solid_mem [MAX_WIDTH];
    logic [DV_W-1:0] dist_mem  [MAX_WIDTH];
    logic [1:0]      srd_reg;
    logic [DV_W-1:0] drd_reg;
    logic            fwd_reg;
    logic [1:0]      fwd_s_reg;
    logic [DV_W-1:0] fwd_d_reg;

    logic [1:0]      s_rd;
    logic [DV_W-1:0] d_rd;
    logic [2:0]      new_col;
    logic [1:0]      s_wr;
    logic [2:0]      c0_reg;
    logic [2:0]      c1_reg;
    logic [DV_W-1:0] d_prev_reg;
    logic [2:0]      win_l;
    logic [2:0]      win_m;
    logic [2:0]      win_r;
    logic            settle_en;

    logic signed [CONTRIB_W-1:0] dx;
    logic signed [CONTRIB_W-1:0] dy;
    settle_req_t                 req_next;
    settle_req_t                 req_reg;

    function automatic logic signed [CONTRIB_W-1:0] take(input logic [DW-1:0] f,
                                                         input logic en);
        logic signed [CONTRIB_W-1:0] v;
        v = en ? CONTRIB_W'(f) : '0;
        return v;
    endfunction

    // clamp geometry to 1..max
    always_comb
    begin
        if (grid_width == '0)
            eff_w = WW'(1);
        else if (32'(grid_width) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(grid_width);
        if (grid_height == '0)
            eff_h = HW'(1);
        else if (32'(grid_height) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(grid_height);
    end

    // rows 0..h-1 take input, row h is a solid-free drain row, row h+1 flushes
    assign in_frame  = 32'(y_reg) < 32'(eff_h);
    assign drain_row = 32'(y_reg) == 32'(eff_h);
    assign flush_row = 32'(y_reg) == 32'(eff_h) + 1;
    assign flush_ok  = !coef_busy && !p1_last_reg && !req_reg.last;
    assign step_go   = (in_frame && in_valid) || drain_row || (flush_row && flush_ok);
    assign last_col  = 32'(x_reg) == 32'(eff_w) - 1;
    assign in_ready  = in_frame;

    for (genvar q = 0; q < 8; q++)
    begin : g_dist
        logic [31:0] wide;
        assign wide = 32'(in_dist[q*FIELD_W +: FIELD_W]);
        assign dist_now[q*DW +: DW] = wide[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (restart)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (step_go)
        begin
            if (flush_row)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (last_col)
            begin
                x_reg <= '0;
                y_reg <= y_reg + YW'(1);
            end
            else
            begin
                x_reg <= x_reg + XW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p1_last_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= step_go;
            p1_last_reg  <= step_go && flush_row;
            fwd_reg      <= step_go && p1_valid_reg && (p1_x_reg == x_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            p1_x_reg     <= x_reg;
            p1_x0_reg    <= (x_reg == '0);
            p1_ge1_reg   <= (y_reg != '0);
            p1_ge2_reg   <= (32'(y_reg) >= 2);
            p1_solid_reg <= in_frame && in_solid;
            p1_dist_reg  <= dist_now;
            fwd_s_reg    <= s_wr;
            fwd_d_reg    <= p1_dist_reg;
        end
    end

    // line buffers: solid entry holds rows y-1 and y-2, dist holds row y-1
    always_ff @(posedge clk)
    begin
        if (step_go)
        begin
            srd_reg <= solid_mem[x_reg];
            drd_reg <= dist_mem[x_reg];
        end
        if (p1_valid_reg)
        begin
            solid_mem[p1_x_reg] <= s_wr;
            dist_mem[p1_x_reg]  <= p1_dist_reg;
        end
    end

    assign s_rd    = fwd_reg ? fwd_s_reg : srd_reg;
    assign d_rd    = fwd_reg ? fwd_d_reg : drd_reg;
    assign new_col = {p1_solid_reg, s_rd[1] & p1_ge1_reg, s_rd[0] & p1_ge2_reg};
    assign s_wr    = new_col[2:1];

    // at column 0 the window closes the previous row with an outside column
    assign win_r     = p1_x0_reg ? 3'b000 : new_col;
    assign win_m     = c0_reg;
    assign win_l     = c1_reg;
    assign settle_en = p1_x0_reg ? p1_ge2_reg : p1_ge1_reg;

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            c0_reg     <= new_col;
            c1_reg     <= p1_x0_reg ? 3'b000 : c0_reg;
            d_prev_reg <= d_rd;
        end
    end

    // window bits: [0] row above source, [1] same row, [2] row below
    always_comb
    begin
        dx = take(d_prev_reg[0*DW +: DW], win_l[1])
           - take(d_prev_reg[2*DW +: DW], win_r[1])
           + take(d_prev_reg[4*DW +: DW], win_l[0])
           - take(d_prev_reg[5*DW +: DW], win_r[0])
           - take(d_prev_reg[6*DW +: DW], win_r[2])
           + take(d_prev_reg[7*DW +: DW], win_l[2]);
        dy = take(d_prev_reg[1*DW +: DW], win_m[0])
           - take(d_prev_reg[3*DW +: DW], win_m[2])
           + take(d_prev_reg[4*DW +: DW], win_l[0])
           + take(d_prev_reg[5*DW +: DW], win_r[0])
           - take(d_prev_reg[6*DW +: DW], win_r[2])
           - take(d_prev_reg[7*DW +: DW], win_l[2]);
        req_next.valid = p1_valid_reg && settle_en && !win_m[1];
        req_next.last  = p1_valid_reg && p1_last_reg;
        req_next.dx2   = dx <<< 1;
        req_next.dy2   = dy <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_reg <= '0;
        else
            req_reg <= req_next;
    end

    assign req = req_reg;

    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        req_reg.last |-> !coef_busy)
        else $error("frame end reached a busy coefficient unit");

    a_flush_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && flush_row && !restart |=> x_reg == '0 && y_reg == '0)
        else $error("flush step did not start a new frame");

endmodule

@@ sv/mefs_acc.sv @@
// saturating drag and lift accumulators with end-of-frame handoff
module mefs_acc
    import mefs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        restart,
    input  settle_req_t req,
    output frame_sum_t  sum
);

    logic signed [SUM_W-1:0] drag_reg;
    logic signed [SUM_W-1:0] lift_reg;
    logic                    clip_reg;
    logic signed [SUM_W:0]   drag_wide;
    logic signed [SUM_W:0]   lift_wide;
    logic signed [SUM_W-1:0] drag_next;
    logic signed [SUM_W-1:0] lift_next;
    logic                    clip_next;
    frame_sum_t              sum_reg;

    always_comb
    begin
        drag_wide = {drag_reg[SUM_W-1], drag_reg} + (SUM_W+1)'($signed(req.dx2));
        lift_wide = {lift_reg[SUM_W-1], lift_reg} + (SUM_W+1)'($signed(req.dy2));
        drag_next = drag_reg;
        lift_next = lift_reg;
        clip_next = clip_reg;
        if (req.valid)
        begin
            if (drag_wide[SUM_W] != drag_wide[SUM_W-1])
            begin
                drag_next = drag_wide[SUM_W] ? SUM_MIN : SUM_MAX;
                clip_next = 1'b1;
            end
            else
                drag_next = drag_wide[SUM_W-1:0];
            if (lift_wide[SUM_W] != lift_wide[SUM_W-1])
            begin
                lift_next = lift_wide[SUM_W] ? SUM_MIN : SUM_MAX;
                clip_next = 1'b1;
            end
            else
                lift_next = lift_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_reg <= '0;
            lift_reg <= '0;
            clip_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else if (restart)
        begin
            drag_reg      <= '0;
            lift_reg      <= '0;
            clip_reg      <= 1'b0;
            sum_reg.valid <= 1'b0;
        end
        else
        begin
            sum_reg.valid <= req.last;
            if (req.last)
            begin
                sum_reg.drag <= drag_next;
                sum_reg.lift <= lift_next;
                sum_reg.clip <= clip_next;
                drag_reg     <= '0;
                lift_reg     <= '0;
                clip_reg     <= 1'b0;
            end
            else
            begin
                drag_reg <= drag_next;
                lift_reg <= lift_next;
                clip_reg <= clip_next;
            end
        end
    end

    assign sum = sum_reg;

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg.valid |-> drag_reg == '0 && lift_reg == '0 && !clip_reg)
        else $error("accumulators not cleared at frame end");

endmodule

@@ sv/mefs_coef.sv @@
// coefficient scaling: split multiply, rounding, saturation and result register
module mefs_coef
    import mefs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SCALE_W-1:0]     coef_scale,
    input  frame_sum_t             sum,
    output logic                   busy,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SUM_W-1:0]       drag_sum,
    output logic [SUM_W-1:0]       lift_sum,
    output logic [SUM_W-1:0]       drag_coef,
    output logic [SUM_W-1:0]       lift_coef,
    output logic                   saturated
);

    localparam logic [63:0] MAG_MAX = 64'(SUM_MAX);

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    logic signed [SUM_W-1:0] drag_raw_reg;
    logic signed [SUM_W-1:0] lift_raw_reg;
    logic                    clip_reg;
    logic [1:0]              neg_reg;
    logic [1:0][SUM_W-1:0]   mag_reg;
    logic [1:0][39:0]        p_lh_reg, p_hh_reg, p_ll_reg, p_hl_reg;
    logic [1:0][63:0]        hi_full_reg, lo_full_reg;
    logic [1:0][63:0]        magc_reg;
    logic [1:0][SUM_W-1:0]   coef_reg;
    logic                    sat_out_reg;
    logic [1:0][SUM_W-1:0]   coef_next;
    logic [1:0]              clip_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= sum.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (v4_reg)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum.valid)
        begin
            drag_raw_reg <= sum.drag;
            lift_raw_reg <= sum.lift;
            clip_reg     <= sum.clip;
            neg_reg      <= {sum.lift[SUM_W-1], sum.drag[SUM_W-1]};
            mag_reg[0]   <= sum.drag[SUM_W-1] ? SUM_W'(-sum.drag) : SUM_W'(sum.drag);
            mag_reg[1]   <= sum.lift[SUM_W-1] ? SUM_W'(-sum.lift) : SUM_W'(sum.lift);
        end
        for (int k = 0; k < 2; k++)
        begin
            // 24x16 partial products of magnitude and scale halves
            p_lh_reg[k] <= 40'(mag_reg[k][23:0])  * 40'(coef_scale[31:16]);
            p_hh_reg[k] <= 40'(mag_reg[k][47:24]) * 40'(coef_scale[31:16]);
            p_ll_reg[k] <= 40'(mag_reg[k][23:0])  * 40'(coef_scale[15:0]);
            p_hl_reg[k] <= 40'(mag_reg[k][47:24]) * 40'(coef_scale[15:0]);
            hi_full_reg[k] <= (64'(p_hh_reg[k]) << 24) + 64'(p_lh_reg[k]);
            lo_full_reg[k] <= (64'(p_hl_reg[k]) << 24) + 64'(p_ll_reg[k]) + 64'h8000;
            magc_reg[k]    <= hi_full_reg[k] + (lo_full_reg[k] >> 16);
        end
        if (v4_reg)
        begin
            coef_reg    <= coef_next;
            sat_out_reg <= clip_reg | clip_k[0] | clip_k[1];
        end
    end

    // sign restore with saturation; the most negative value is exact
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            clip_k[k] = 1'b0;
            if (neg_reg[k])
            begin
                if (magc_reg[k] > MAG_MAX + 64'd1)
                begin
                    clip_k[k]    = 1'b1;
                    coef_next[k] = SUM_MIN;
                end
                else if (magc_reg[k] == MAG_MAX + 64'd1)
                    coef_next[k] = SUM_MIN;
                else
                    coef_next[k] = SUM_W'(-magc_reg[k]);
            end
            else
            begin
                if (magc_reg[k] > MAG_MAX)
                begin
                    clip_k[k]    = 1'b1;
                    coef_next[k] = SUM_MAX;
                end
                else
                    coef_next[k] = magc_reg[k][SUM_W-1:0];
            end
        end
    end

    // a frame total arriving from the accumulators already counts as busy
    assign busy      = sum.valid | v1_reg | v2_reg | v3_reg | v4_reg | out_valid_reg;
    assign m_valid   = out_valid_reg;
    assign drag_sum  = drag_raw_reg;
    assign lift_sum  = lift_raw_reg;
    assign drag_coef = coef_reg[0];
    assign lift_coef = coef_reg[1];
    assign saturated = sat_out_reg;

    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg}))
        else $error("more than one frame result in flight");

endmodule

@@ sv/momentum_exchange_force_sum_unit.sv @@
// top level of the D2Q9 momentum exchange drag and lift sum unit
//
//  port group   dir  carries
//  s_axis_*     in   one lattice cell per request, raster order
//  m_axis_*     out  one result per frame: sums, coefficients, clip flag
//  cfg_*        in   register writes: grid_width, grid_height, coef_scale
//
// one cell is taken per cycle while a frame's rows stream in
// after the last row the unit runs one drain row and one flush step with
//   s_axis_tready low; these set the per-frame overhead
// the flush step waits while the previous frame's result is still in flight or unread
// the result follows the flush step through the window, contribution and
//   accumulator registers, then a five-stage split 48x32 coefficient multiply
//   ending in the output register
// line buffers are not cleared at reset; rows not yet written are masked off
// writing grid_width or grid_height restarts the frame
module momentum_exchange_force_sum_unit
    import mefs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int DIST_BITS  = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // is_solid, f_east, f_north, f_west, f_south,
    // f_northeast, f_northwest, f_southwest, f_southeast, zero pad
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // drag_sum, lift_sum, drag_coef, lift_coef, saturated, zero pad
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [SCALE_W-1:0]      cfg_wdata
);

    logic [CFG_W-1:0]   grid_width_reg;
    logic [CFG_W-1:0]   grid_height_reg;
    logic [SCALE_W-1:0] coef_scale_reg;
    logic               restart;

    settle_req_t        req;
    frame_sum_t         sum;
    logic               coef_busy;

    logic [SUM_W-1:0]   drag_sum;
    logic [SUM_W-1:0]   lift_sum;
    logic [SUM_W-1:0]   drag_coef;
    logic [SUM_W-1:0]   lift_coef;
    logic               saturated;

    // geometry writes restart the frame, the scale takes effect at once
    assign restart = cfg_we && (cfg_addr == REG_GRID_WIDTH || cfg_addr == REG_GRID_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(256);
            grid_height_reg <= CFG_W'(256);
            coef_scale_reg  <= SCALE_W'(51200);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[CFG_W-1:0];
                REG_COEF_SCALE:  coef_scale_reg  <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // cell window and per-cell momentum exchange
    mefs_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DIST_BITS  (DIST_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_solid    (s_axis_tdata[0]),
        .in_dist     (s_axis_tdata[8*FIELD_W:1]),
        .coef_busy   (coef_busy),
        .req         (req)
    );

    // running sums in raster order of fluid cells
    mefs_acc u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .req     (req),
        .sum     (sum)
    );

    // frame result: scaled coefficients and output register
    mefs_coef u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_scale (coef_scale_reg),
        .sum        (sum),
        .busy       (coef_busy),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .drag_sum   (drag_sum),
        .lift_sum   (lift_sum),
        .drag_coef  (drag_coef),
        .lift_coef  (lift_coef),
        .saturated  (saturated)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 4*SUM_W - 1){1'b0}}, saturated,
                           lift_coef, drag_coef, lift_sum, drag_sum};

endmodule

@@ sim/momentum_exchange_force_sum_unit_checker.sv @@
// stream monitor, frame total predictor and result comparator for the force sum unit
module momentum_exchange_force_sum_unit_checker
    import mefs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [SCALE_W-1:0]     cfg_wdata,
    output int                     mismatches,
    output int                     pending,
    output int                     clipped_frames
);

    localparam int GRID_MAX = 1024;
    localparam longint S_MAX = 64'sd140737488355327;
    localparam longint S_MIN = -64'sd140737488355328;

    typedef struct packed {
        logic [SUM_W-1:0] drag;
        logic [SUM_W-1:0] lift;
        logic [SUM_W-1:0] drag_coef;
        logic [SUM_W-1:0] lift_coef;
        logic             clip;
    } frame_totals_t;

    frame_totals_t totals_q[$];

    // east, north, west, south, northeast, northwest, southwest, southeast
    int dir_dx[8] = '{1, 0, -1, 0, 1, -1, -1, 1};
    int dir_dy[8] = '{0, 1, 0, -1, 1, 1, -1, -1};

    bit                 solid_mem[3][GRID_MAX];
    logic [FIELD_W-1:0] dist_mem[2][GRID_MAX][8];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [SCALE_W-1:0] scale_reg;
    longint             drag_acc;
    longint             lift_acc;
    int                 col;
    int                 row;
    bit                 clip;

    function automatic int clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return int'(v);
    endfunction

    function automatic longint add_clipped(input longint a, input longint b, inout bit c);
        longint s;
        s = a + b;
        if (s > S_MAX)
        begin
            c = 1;
            return S_MAX;
        end
        if (s < S_MIN)
        begin
            c = 1;
            return S_MIN;
        end
        return s;
    endfunction

    task automatic settle_row(input int r, input int w, input int h);
        longint dx;
        longint dy;
        int     sx;
        int     sy;
        for (int x = 0; x < w; x++)
        begin
            if (!solid_mem[r % 3][x])
            begin
                dx = 0;
                dy = 0;
                for (int q = 0; q < 8; q++)
                begin
                    sx = x - dir_dx[q];
                    sy = r - dir_dy[q];
                    if (sx >= 0 && sx < w && sy >= 0 && sy < h && solid_mem[sy % 3][sx])
                    begin
                        dx += dir_dx[q] * longint'(dist_mem[r % 2][x][q]);
                        dy += dir_dy[q] * longint'(dist_mem[r % 2][x][q]);
                    end
                end
                drag_acc = add_clipped(drag_acc, 2 * dx, clip);
                lift_acc = add_clipped(lift_acc, 2 * dy, clip);
            end
        end
    endtask

    // magnitude times scale, rounded half away from zero, sign restored
    function automatic longint scaled_coef(input longint s, input logic [31:0] k, inout bit c);
        longint unsigned m;
        longint unsigned mag;
        longint unsigned lim;
        m   = (s < 0) ? longint'(-s) : longint'(s);
        mag = m * k[31:16] + ((m * k[15:0] + 64'h8000) >> 16);
        lim = longint'(S_MAX);
        if (s >= 0)
        begin
            if (mag > lim)
            begin
                c = 1;
                return S_MAX;
            end
            return longint'(mag);
        end
        if (mag > lim + 1)
        begin
            c = 1;
            return S_MIN;
        end
        return -longint'(mag);
    endfunction

    task automatic take_cell(input logic [IN_TDATA_W-1:0] d);
        int            w;
        int            h;
        frame_totals_t t;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        if (col >= w)
            col = 0;
        if (row >= h)
            row = 0;
        solid_mem[row % 3][col] = d[0];
        for (int q = 0; q < 8; q++)
            dist_mem[row % 2][col][q] = d[1 + q*FIELD_W +: FIELD_W];
        col++;
        if (col < w)
            return;
        col = 0;
        if (row >= 1)
            settle_row(row - 1, w, h);
        if (row < h - 1)
        begin
            row++;
            return;
        end
        settle_row(row, w, h);
        t.drag      = drag_acc[SUM_W-1:0];
        t.lift      = lift_acc[SUM_W-1:0];
        t.drag_coef = scaled_coef(drag_acc, scale_reg, clip);
        t.lift_coef = scaled_coef(lift_acc, scale_reg, clip);
        t.clip      = clip;
        totals_q.push_back(t);
        drag_acc = 0;
        lift_acc = 0;
        row      = 0;
        clip     = 0;
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
        frame_totals_t want;
        frame_totals_t got;
        got.drag      = d[0 +: SUM_W];
        got.lift      = d[SUM_W +: SUM_W];
        got.drag_coef = d[2*SUM_W +: SUM_W];
        got.lift_coef = d[3*SUM_W +: SUM_W];
        got.clip      = d[4*SUM_W];
        if (totals_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: drag %h lift %h", got.drag, got.lift);
            return;
        end
        want = totals_q.pop_front();
        if (got.clip)
            clipped_frames++;
        if (got != want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch drag %h/%h lift %h/%h dcoef %h/%h lcoef %h/%h sat %b/%b",
                         want.drag, got.drag, want.lift, got.lift,
                         want.drag_coef, got.drag_coef, want.lift_coef, got.lift_coef,
                         want.clip, got.clip);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      = 11'd256;
            height_reg     = 11'd256;
            scale_reg      = 32'd51200;
            drag_acc       = 0;
            lift_acc       = 0;
            col            = 0;
            row            = 0;
            clip           = 0;
            mismatches     = 0;
            pending        = 0;
            clipped_frames = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_addr))
                    REG_GRID_WIDTH:  width_reg  = cfg_wdata[CFG_W-1:0];
                    REG_GRID_HEIGHT: height_reg = cfg_wdata[CFG_W-1:0];
                    REG_COEF_SCALE:  scale_reg  = cfg_wdata;
                    default: ;
                endcase
                if (cfg_addr == REG_GRID_WIDTH || cfg_addr == REG_GRID_HEIGHT)
                begin
                    drag_acc = 0;
                    lift_acc = 0;
                    col      = 0;
                    row      = 0;
                    clip     = 0;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_cell(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            pending = totals_q.size();
        end
    end

endmodule

@@ sim/momentum_exchange_force_sum_unit_tb.sv @@
// stimulus, reset, clocking and verdict for the force sum unit testbench
module momentum_exchange_force_sum_unit_tb;
    import mefs_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [SCALE_W-1:0]     cfg_wdata;

    int mismatches;
    int pending;
    int clipped_frames;

    // sender pacing and counters
    int burst_left;
    int gap_max;
    int cells_sent;
    int frames_sent;
    int long_hold_req;

    // solid pattern choices for a frame
    localparam int SOLID_RANDOM = 0;
    localparam int SOLID_COLUMN = 1;
    // distribution value choices
    localparam int F_RANDOM = 0;
    localparam int F_MAX    = 1;
    localparam int F_ZERO   = 2;
    localparam int F_MIXED  = 3;

    momentum_exchange_force_sum_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    momentum_exchange_force_sum_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatches     (mismatches),
        .pending        (pending),
        .clipped_frames (clipped_frames)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #60000000;
        $display("momentum_exchange_force_sum_unit_tb NOT OK");
        $finish;
    end

    // receiver: random stall pattern whose stall rate changes from phase to phase,
    // plus one long hold-off on request so the block backs up into its input
    initial
    begin
        int stall_pct;
        int phase_left;
        int hold_left;
        int hold_seen;
        stall_pct     = 0;
        phase_left    = 0;
        hold_left     = 0;
        hold_seen     = 0;
        m_axis_tready = 0;
        forever
        begin
            @(posedge clk);
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    2:       stall_pct = 70;
                    default: stall_pct = 95;
                endcase
            end
            phase_left--;
            if (long_hold_req != hold_seen)
            begin
                hold_seen = long_hold_req;
                hold_left = 2500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic int used_dim(input int v);
        if (v == 0)
            return 1;
        if (v > 1024)
            return 1024;
        return v;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_dist(input int mode);
        case (mode)
            F_MAX:  return {FIELD_W{1'b1}};
            F_ZERO: return '0;
            F_MIXED:
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return {FIELD_W{1'b1}};
                    default: return FIELD_W'($urandom_range(0, 32'hFFFFFF));
                endcase
            default: return FIELD_W'($urandom_range(0, 32'hFFFFFF));
        endcase
    endfunction

    // one cell request, honoring the burst and gap pattern of the sender
    task automatic push_cell(input logic solid, input logic [8*FIELD_W-1:0] dists);
        if (burst_left == 0)
        begin
            if (gap_max > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, dists, solid};
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        burst_left--;
        cells_sent++;
    endtask

    // sender pause: everything drained, then room for the block to settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_geometry(input int w, input int h, input logic [31:0] k);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_GRID_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= REG_GRID_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_addr  <= REG_COEF_SCALE;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // a group of whole frames under one register setting
    task automatic run_frames(input int w, input int h, input logic [31:0] k, input int nframes,
                              input int solid_pct, input int solid_mode, input int fmode);
        int                   wu;
        int                   hu;
        logic                 solid;
        logic [8*FIELD_W-1:0] dists;
        wait_drained();
        write_geometry(w, h, k);
        wu = used_dim(w);
        hu = used_dim(h);
        for (int n = 0; n < nframes; n++)
        begin
            for (int i = 0; i < wu * hu; i++)
            begin
                if (solid_mode == SOLID_COLUMN)
                    solid = (i % wu == 0);
                else
                    solid = ($urandom_range(0, 99) < solid_pct);
                for (int q = 0; q < 8; q++)
                    dists[q*FIELD_W +: FIELD_W] = pick_dist(fmode);
                push_cell(solid, dists);
            end
            frames_sent++;
        end
    endtask

    initial
    begin
        int w;
        int h;
        logic [31:0] k;
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        cfg_we        = 0;
        cfg_addr      = REG_GRID_WIDTH;
        cfg_wdata     = '0;
        burst_left    = 0;
        gap_max       = 0;
        cells_sent    = 0;
        frames_sent   = 0;
        long_hold_req = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero geometry used as one cell: zero scale with all-zero values, then max scale with all-max values
        run_frames(0, 0, 32'd0, 2, 50, SOLID_RANDOM, F_ZERO);
        run_frames(0, 0, 32'hFFFFFFFF, 2, 50, SOLID_RANDOM, F_MAX);
        // small square with every kind of neighbor, edges included
        run_frames(3, 3, 32'd51200, 2, 50, SOLID_RANDOM, F_MIXED);
        // solid wall on the left with max values and max scale: coefficients clip
        gap_max = 3;
        run_frames(2, 32, 32'hFFFFFFFF, 1, 0, SOLID_COLUMN, F_MAX);
        // widest grid from a register value above the maximum, then a tall column
        gap_max = 0;
        run_frames(2047, 1, 32'h00010000, 1, 40, SOLID_RANDOM, F_RANDOM);
        run_frames(1, 100, 32'h00008000, 1, 40, SOLID_RANDOM, F_RANDOM);

        // back-to-back small frames while the receiver holds off for a long stretch
        gap_max       = 0;
        long_hold_req = 1;
        run_frames(4, 3, 32'd51200, 10, 40, SOLID_RANDOM, F_RANDOM);

        // random part: groups of frames under random settings
        while (cells_sent < 1550)
        begin
            w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
            case ($urandom_range(0, 4))
                0:       k = 32'd0;
                1:       k = 32'hFFFFFFFF;
                default: k = $urandom;
            endcase
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            run_frames(w, h, k, $urandom_range(1, 3), $urandom_range(0, 100),
                       ($urandom_range(0, 7) == 0) ? SOLID_COLUMN : SOLID_RANDOM,
                       $urandom_range(F_RANDOM, F_MIXED));
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("ran %0d cells in %0d frames across random grid sizes and scales",
                 cells_sent, frames_sent);
        $display("%0d results came out clipped, %0d mismatches", clipped_frames, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("momentum_exchange_force_sum_unit_tb OK");
        else
            $display("momentum_exchange_force_sum_unit_tb NOT OK");
        $finish;
    end

endmodule
